[sv/linear_probe_hash_table_unit_macros.svh]
// Assertion shorthands, clocked on clk, masked while rst_n is low.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define LPHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht check failed");

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht check failed");

`endif

[sv/lpht_pkg.sv]
package lpht_pkg;

  // Slot count; home slot is taken as the low index bits of the key,
  // so keep this a power of two.
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  localparam int KEY_W  = 31;
  localparam int DATA_W = 32;

  localparam int IN_TDATA_W  = 72;  // 2 + 31 + 32 = 65, padded to bytes
  localparam int OUT_TDATA_W = 40;  // 2 + 32 = 34, padded to bytes

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_t;

  // One table row: state, key, value.
  localparam int ROW_W = 2 + KEY_W + DATA_W;

  typedef struct packed {
    logic    capture;   // take the request, start at home slot
    logic    advance;   // step to the next slot
    logic    wr_en;     // write the current row
    logic    wr_del;    // row write marks the slot deleted (else insert)
    logic    res_load;  // latch the result
    status_t res_status;
    logic    res_take;  // result carries the slot value
    logic    out_load;  // move result into the output register
  } lpht_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  slot_empty;
    logic  slot_used;
    logic  key_hit;
    logic  last_probe;
    logic  out_free;
  } lpht_stat_t;

endpackage

[sv/lpht_ram.sv]
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/lpht_ctrl.sv]
module lpht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lpht_pkg::lpht_stat_t stat,
  output lpht_pkg::lpht_cmd_t  cmd
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = ST_NOT_FOUND;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;  // row of the home slot arrives
      end
      S_CHECK: begin
        case (stat.mode)
          MODE_SEARCH, MODE_DELETE: begin
            if (stat.slot_empty) begin
              cmd.res_load = 1'b1;
            end else if (stat.slot_used && stat.key_hit) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_OK;
              cmd.res_take   = 1'b1;
              cmd.wr_en      = (stat.mode == MODE_DELETE);
              cmd.wr_del     = 1'b1;
            end else if (stat.last_probe) begin
              cmd.res_load = 1'b1;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          MODE_INSERT: begin
            if (!stat.slot_used) begin
              cmd.wr_en      = 1'b1;
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_OK;
            end else if (stat.last_probe) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
          end
        endcase
        if (cmd.res_load) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/lpht_dp.sv]
module lpht_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lpht_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lpht_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  lpht_pkg::lpht_cmd_t               cmd,
  output lpht_pkg::lpht_stat_t              stat
);
  import lpht_pkg::*;

  // Request fields
  mode_t                    mode_r;
  logic        [KEY_W-1:0]  key_r;
  logic signed [DATA_W-1:0] data_r;

  // Probe position
  logic [IDX_W-1:0] idx_r, idx_nxt, idx_inc;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] rd_addr;

  // Row store plus per-row valid bits (a row never written reads as empty)
  logic [TABLE_SIZE-1:0] vld_r;
  logic                  rd_vld_r;
  logic [ROW_W-1:0]      rd_row, wr_row;
  slot_t                 rd_state;
  logic [KEY_W-1:0]      rd_key;
  logic [DATA_W-1:0]     rd_value;

  // Result and output register
  status_t                  res_status_r;
  logic signed [DATA_W-1:0] res_data_r;
  logic                     out_tvalid_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_data_r;

  assign idx_inc = (idx_r == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_r + 1'b1;
  assign idx_nxt = cmd.capture ? in_tdata[2 +: IDX_W] : idx_inc;
  // Next slot is addressed the cycle it is stepped to, one probe a cycle.
  assign rd_addr = (cmd.capture || cmd.advance) ? idx_nxt : idx_r;

  assign rd_state = rd_vld_r ? slot_t'(rd_row[ROW_W-1 -: 2]) : SLOT_EMPTY;
  assign rd_key   = rd_row[DATA_W +: KEY_W];
  assign rd_value = rd_row[DATA_W-1:0];

  assign wr_row = cmd.wr_del ? {SLOT_DELETED, rd_key, rd_value}
                             : {SLOT_USED, key_r, data_r};

  lpht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_SIZE)
  ) u_rows (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (idx_r),
    .wdata (wr_row),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[idx_r] <= 1'b1;
    end
    rd_vld_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_tdata[1:0]);
      key_r  <= in_tdata[2 +: KEY_W];
      data_r <= in_tdata[2 + KEY_W +: DATA_W];
      idx_r  <= idx_nxt;
      cnt_r  <= '0;
    end else if (cmd.advance) begin
      idx_r <= idx_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_data_r   <= cmd.res_take ? rd_value : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign stat.mode       = mode_r;
  assign stat.slot_empty = (rd_state == SLOT_EMPTY);
  assign stat.slot_used  = (rd_state == SLOT_USED);
  assign stat.key_hit    = (rd_key == key_r);
  assign stat.last_probe = (cnt_r == IDX_W'(TABLE_SIZE - 1));
  assign stat.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 - DATA_W){1'b0}}, out_data_r, out_status_r};

endmodule

[sv/linear_probe_hash_table_unit.sv]
// Each request probes from its home slot, 1..TABLE_SIZE slots, until it resolves.
// A new request is taken only once the last result has moved to the output register;
//   the single read port of the row RAM sets the pace: one slot is examined per cycle.
// Reset (rst_n low, synchronous): every slot reads empty at once via per-row valid
//   bits; no clearing pass. Output channel goes idle.
module linear_probe_hash_table_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lpht_pkg::IN_TDATA_W-1:0]  in_tdata,   // mode[1:0], key[32:2], data[64:33], pad
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lpht_pkg::OUT_TDATA_W-1:0] out_tdata   // status[1:0], data_out[33:2], pad
);
  import lpht_pkg::*;

  // Controller walks IDLE -> READ -> CHECK (one slot per cycle) -> DONE.
  // Datapath holds the request, probe index/count, the row RAM and the
  // output register, so the next request can be taken while a result waits.
  lpht_cmd_t  cmd;
  lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

[sv/lpht_checker.sv]
`include "linear_probe_hash_table_unit_macros.svh"

module lpht_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lpht_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lpht_pkg::*;

  // A stalled result holds.
  `LPHT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Only defined status codes leave the block.
  `LPHT_ASSERT_NOW(a_status_code, out_tvalid, out_tdata[1:0] != 2'd3)

  // Misses and full-table results carry zero data.
  `LPHT_ASSERT_NOW(a_miss_zero, out_tvalid && out_tdata[1:0] != ST_OK,
                   out_tdata[2 +: DATA_W] == '0)

  // One request in flight: ready drops right after an accept.
  `LPHT_ASSERT_NEXT(a_one_busy, in_tvalid && in_tready, !in_tready)

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (.*);
